FILE: sv/tspi_pkg.sv
// Shared types and constants for the timed sample playback interpolator.
package tspi_pkg;

    localparam int IDX_W    = 10;
    localparam int CH_W     = 4;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 11;
    localparam int WGT_W    = 17;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    localparam logic [1:0] KIND_DROP  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  idx;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] time_us;
        logic [VAL_W-1:0]  value;
    } tspi_item_t;

endpackage

FILE: sv/tspi_ram.sv
// Generic single-port RAM with registered read.
module tspi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/tspi_front.sv
// Input side: accepts words, classifies them and queues them for the sequencer.
module tspi_front
    import tspi_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int CHANNELS    = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [0:0]          s_tuser,
    output logic                q_valid,
    output tspi_item_t          q_item,
    input  logic                q_pop
);

    tspi_item_t item_in;
    tspi_item_t fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;

    always_comb
    begin
        item_in.idx     = s_tdata[9:0];
        item_in.ch      = s_tdata[13:10];
        item_in.time_us = s_tdata[45:14];
        item_in.value   = s_tdata[77:46];
        if (s_tuser[0])
        begin
            item_in.kind = KIND_QUERY;
        end
        else if (32'(item_in.idx) < 32'(MAX_ENTRIES) && 32'(item_in.ch) < 32'(CHANNELS))
        begin
            item_in.kind = KIND_LOAD;
        end
        else
        begin
            item_in.kind = KIND_DROP;
        end
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: sv/tspi_back.sv
// Sequencer: table writes, index walk, weight division and per-channel lerp.
module tspi_back
    import tspi_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int CHANNELS    = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    count,
    input  logic                q_valid,
    input  tspi_item_t          q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int VAW = $clog2(MAX_ENTRIES * CHANNELS) > 0 ? $clog2(MAX_ENTRIES * CHANNELS) : 1;
    localparam int CW  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WRD  = 4'd1;
    localparam logic [3:0] S_WCHK = 4'd2;
    localparam logic [3:0] S_TP   = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_VP   = 4'd5;
    localparam logic [3:0] S_VC   = 4'd6;
    localparam logic [3:0] S_VM   = 4'd7;
    localparam logic [3:0] S_VO   = 4'd8;
    localparam logic [3:0] S_ERR  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  play_reg;
    logic [CW-1:0]     c_reg;
    logic [4:0]        dcnt_reg;
    logic [TIME_W-1:0] now_reg, tc_reg, dt_reg, otime_reg;
    logic [32:0]       r_reg;
    logic [WGT_W-1:0]  q_reg, w_reg;
    logic [VAL_W-1:0]  prev_reg;
    logic [50:0]       prod_reg;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              out_status_reg, out_last_reg;

    logic              t_we, v_we;
    logic [AW-1:0]     t_addr;
    logic [VAW-1:0]    v_addr;
    logic [TIME_W-1:0] t_rd;
    logic [VAL_W-1:0]  v_rd;
    logic [CNT_W-1:0]  rec_prev;
    logic              out_free;
    logic [32:0]       r_sh, r_sub;
    logic              ge;
    logic [WGT_W-1:0]  q_new;
    logic [32:0]       diff;
    logic [50:0]       rnd;
    logic [VAL_W-1:0]  lerp_val;
    logic              last_ch;

    assign rec_prev = (play_reg == '0) ? '0 : play_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign last_ch  = (32'(c_reg) == 32'(CHANNELS - 1));

    // table port control
    always_comb
    begin
        t_we = q_pop && (q_item.kind == KIND_LOAD);
        v_we = t_we;
        case (state_reg)
            S_IDLE:  t_addr = AW'(q_item.idx);
            S_WCHK:  t_addr = AW'(rec_prev);
            default: t_addr = AW'(play_reg);
        endcase
        case (state_reg)
            S_VP:    v_addr = VAW'(rec_prev) * VAW'(CHANNELS) + VAW'(c_reg);
            S_VC:    v_addr = VAW'(play_reg) * VAW'(CHANNELS) + VAW'(c_reg);
            default: v_addr = VAW'(q_item.idx) * VAW'(CHANNELS) + VAW'(q_item.ch);
        endcase
    end

    tspi_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ENTRIES)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .addr  (t_addr),
        .wdata (q_item.time_us),
        .rdata (t_rd)
    );

    tspi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES * CHANNELS)) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (q_item.value),
        .rdata (v_rd)
    );

    // one restoring step; the first step takes the integer bit unshifted
    always_comb
    begin
        r_sh  = (dcnt_reg == 5'd0) ? r_reg : {r_reg[31:0], 1'b0};
        ge    = (r_sh >= {1'b0, dt_reg});
        r_sub = ge ? r_sh - {1'b0, dt_reg} : r_sh;
        q_new = {q_reg[WGT_W-2:0], ge};
    end

    always_comb
    begin
        diff     = {v_rd[31], v_rd} - {prev_reg[31], prev_reg};
        rnd      = prod_reg + 51'd32768;
        lerp_val = prev_reg + rnd[47:16];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_item.kind == KIND_QUERY)
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:   state_next = (play_reg >= count) ? S_ERR : S_WCHK;
            S_WCHK:
            begin
                if (t_rd < now_reg)
                begin
                    state_next = S_WRD;
                end
                else if (play_reg == '0)
                begin
                    state_next = S_VP;
                end
                else
                begin
                    state_next = S_TP;
                end
            end
            S_TP:    state_next = (tc_reg <= t_rd) ? S_VP : S_DIV;
            S_DIV:   state_next = (dcnt_reg == 5'd16) ? S_VP : S_DIV;
            S_VP:    state_next = S_VC;
            S_VC:    state_next = S_VM;
            S_VM:    state_next = S_VO;
            S_VO:
            begin
                if (out_free)
                begin
                    state_next = last_ch ? S_IDLE : S_VP;
                end
            end
            S_ERR:   state_next = out_free ? S_IDLE : S_ERR;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            play_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WCHK && t_rd < now_reg)
            begin
                play_reg <= play_reg + CNT_W'(1);
            end
            if ((state_reg == S_VO || state_reg == S_ERR) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                now_reg <= q_item.time_us;
            end
            S_WCHK:
            begin
                tc_reg    <= t_rd;
                c_reg     <= '0;
                w_reg     <= '0;
                otime_reg <= t_rd;
            end
            S_TP:
            begin
                otime_reg <= now_reg;
                w_reg     <= WGT_W'(65536);
                dt_reg    <= tc_reg - t_rd;
                dcnt_reg  <= 5'd0;
                q_reg     <= '0;
                if (now_reg <= t_rd)
                begin
                    r_reg <= '0;
                end
                else if (now_reg >= tc_reg)
                begin
                    r_reg <= {1'b0, tc_reg - t_rd};
                end
                else
                begin
                    r_reg <= {1'b0, now_reg - t_rd};
                end
            end
            S_DIV:
            begin
                r_reg    <= r_sub;
                q_reg    <= q_new;
                dcnt_reg <= dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd16)
                begin
                    w_reg <= q_new;
                end
            end
            S_VC:
            begin
                prev_reg <= v_rd;
            end
            S_VM:
            begin
                // difference sign-extended, weight zero-extended to the full product width
                prod_reg <= $signed({{18{diff[32]}}, diff}) * $signed({34'd0, w_reg});
            end
            S_VO:
            begin
                if (out_free)
                begin
                    out_data_reg   <= {4'd0, otime_reg, lerp_val, 4'(c_reg)};
                    out_status_reg <= 1'b0;
                    out_last_reg   <= last_ch;
                    c_reg          <= c_reg + CW'(1);
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_data_reg   <= '0;
                    out_status_reg <= 1'b1;
                    out_last_reg   <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_status_reg;
    assign m_tlast    = out_last_reg;

endmodule

FILE: sv/timed_sample_playback_interpolator.sv
// Top level of the timed sample playback interpolator.
//
// Usage:
//   s_* stream: one word per load or query. tuser[0] = 0 writes one channel
//   value (entry_index, channel, time_us, sample_value) into the table;
//   tuser[0] = 1 queries the table at time_us. Loads give no output.
//   m_* stream: a query gives CHANNELS words (tlast on the last one), each a
//   linear interpolation between the two records around the query time, or
//   record 0 as stored while the read index is zero. If the index has run
//   past entry_count, one word with tuser = 1 (exhausted) and zero data.
//   cfg_we/cfg_wdata sets entry_count; write it only while idle.
// Sequence:
//   A load is written to the table as the sequencer takes it from the queue.
//   A query walks the read index through S_WRD and S_WCHK per record passed,
//   then divides for the weight in S_DIV (one quotient bit per cycle, skipped
//   at index zero and for unsorted or equal-time records), then runs S_VP,
//   S_VC, S_VM and S_VO per channel; an output stall holds S_VO or S_ERR.
// Reset clears the read index, entry_count and the output valid flag; table
// contents are undefined until loaded. A stalled m_tready holds the output
// word; the two-word input queue keeps accepting until it fills.
module timed_sample_playback_interpolator
    import tspi_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int CHANNELS    = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // entry_index, channel, time_us, sample_value
    input  logic [0:0]          s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_channel, out_value, out_time
    output logic [0:0]          m_tuser,   // status
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata  // entry_count
);

    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] count;
    logic             q_valid;
    logic             q_pop;
    tspi_item_t       q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // counts above the table size act as the table size
    assign count = (32'(entry_count_reg) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : entry_count_reg;

    tspi_front #(.MAX_ENTRIES(MAX_ENTRIES), .CHANNELS(CHANNELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    tspi_back #(.MAX_ENTRIES(MAX_ENTRIES), .CHANNELS(CHANNELS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .count    (count),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/tspi_checker.sv
// Port-level checks for the playback interpolator, bound to the top level.
module tspi_checker
    import tspi_pkg::*;
#(
    parameter int CHANNELS = 14
) (
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser,
    input logic                m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("exhausted word malformed");

    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser[0])
        else $error("error word without last");

    a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser[0] |-> m_tdata[3:0] == 4'(CHANNELS - 1))
        else $error("last word not on final channel");

endmodule

bind timed_sample_playback_interpolator tspi_checker #(.CHANNELS(CHANNELS)) u_tspi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/timed_sample_playback_interpolator_tb.sv
// Self-checking testbench for the timed sample playback interpolator.
`timescale 1ns / 1ps

module timed_sample_playback_interpolator_tb;
    import tspi_pkg::*;

    localparam int NREC    = 1024;
    localparam int NCH     = 14;
    localparam int IDLE_LIM = 20000;  // cycles with no accepted word before giving up
    localparam int SETTLE  = 200;     // covers a trailing load plus the query pipeline

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_EXHAUST = 1'b1;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;

    timed_sample_playback_interpolator #(
        .MAX_ENTRIES(NREC),
        .CHANNELS   (NCH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // entry_index, channel, time_us, sample_value
        .s_tuser  (s_tuser),   // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_channel, out_value, out_time
        .m_tuser  (m_tuser),   // status
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)  // entry_count
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One expected output word.
    typedef struct {
        logic              status;
        logic [CH_W-1:0]   ch;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] tstamp;
        logic              last;
    } playback_word_t;

    playback_word_t playback_q[$];

    // Shadow of the table, the read index and entry_count.
    logic [TIME_W-1:0]       shadow_time [NREC];
    logic signed [VAL_W-1:0] shadow_val  [NREC][NCH];
    logic [NCH-1:0]          shadow_mask [NREC];   // channels written per record
    int unsigned             shadow_index;
    int unsigned             shadow_count;

    int fails;
    int idle_cycles;
    int burst_left;
    int rx_cycle;
    int rx_mode;

    // Directed stimulus rows.
    typedef struct {
        bit                is_cfg;
        logic              func;
        logic [IDX_W-1:0]  idx;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] t;
        logic [VAL_W-1:0]  v;
        bit                exhausted;   // expected word typed in: table exhausted
    } dir_row_t;

    dir_row_t dir_tab[$];

    function automatic int unsigned eff_count();
        return (shadow_count > NREC) ? NREC : shadow_count;
    endfunction

    // Prev + rounded (cur - prev) * w / 2^16.
    function automatic logic [VAL_W-1:0] blend_q16(input logic signed [31:0] p,
                                                   input logic signed [31:0] c,
                                                   input logic [WGT_W-1:0] w);
        logic signed [63:0] d;
        logic signed [63:0] prod;
        logic signed [63:0] term;
        logic signed [63:0] r;
        d    = c;
        d    = d - p;
        prod = d * $signed({47'd0, w});
        term = (prod + 64'sd32768) >>> 16;
        r    = p + term;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // True if a query at 'now' only touches fully loaded records.
    function automatic bit query_is_safe(input logic [TIME_W-1:0] now);
        int unsigned i;
        i = shadow_index;
        while (i < eff_count())
        begin
            if (shadow_mask[i] != {NCH{1'b1}})
                return 1'b0;
            if (shadow_time[i] < now)
                i++;
            else
                break;
        end
        if (i >= eff_count())
            return 1'b1;
        if (i == 0)
            return 1'b1;
        return shadow_mask[i-1] == {NCH{1'b1}};
    endfunction

    // Walks the shadow index and queues the words a query gives.
    function automatic void predict_playback(input logic [TIME_W-1:0] now,
                                             input bit exh_typed);
        playback_word_t  wd;
        logic [63:0]     dt;
        logic [63:0]     a;
        logic [WGT_W-1:0] w;
        logic [TIME_W-1:0] tp;
        logic [TIME_W-1:0] tc;
        while (shadow_index < eff_count() && shadow_time[shadow_index] < now)
            shadow_index++;
        if (exh_typed || shadow_index >= eff_count())
        begin
            wd.status = ST_EXHAUST;
            wd.ch     = '0;
            wd.value  = '0;
            wd.tstamp = '0;
            wd.last   = 1'b1;
            playback_q.push_back(wd);
            return;
        end
        if (shadow_index == 0)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                wd.status = ST_OK;
                wd.ch     = c[CH_W-1:0];
                wd.value  = shadow_val[0][c];
                wd.tstamp = shadow_time[0];
                wd.last   = (c == NCH - 1);
                playback_q.push_back(wd);
            end
            return;
        end
        tp = shadow_time[shadow_index-1];
        tc = shadow_time[shadow_index];
        if (tc <= tp)
            w = 17'd65536;
        else
        begin
            dt = {32'd0, tc} - {32'd0, tp};
            if (now <= tp)
                a = 0;
            else if (now >= tc)
                a = dt;
            else
                a = {32'd0, now} - {32'd0, tp};
            w = WGT_W'((a << 16) / dt);
        end
        for (int c = 0; c < NCH; c++)
        begin
            wd.status = ST_OK;
            wd.ch     = c[CH_W-1:0];
            wd.value  = blend_q16(shadow_val[shadow_index-1][c],
                                  shadow_val[shadow_index][c], w);
            wd.tstamp = now;
            wd.last   = (c == NCH - 1);
            playback_q.push_back(wd);
        end
    endfunction

    // Sends one word; bursts of random length with random gaps in between.
    task automatic send_word(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] t,
                             input logic [VAL_W-1:0] v);
        int gap;
        bit acc;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, v, t, ch, idx};
        // Table shadow follows the load as the block will see it.
        if (func == FUNC_LOAD && ch < NCH)
        begin
            shadow_time[idx]     = t;
            shadow_val[idx][ch]  = v;
            shadow_mask[idx][ch] = 1'b1;
        end
        acc = 1'b0;
        while (!acc)
        begin
            @(negedge clk);
            acc = s_tready;
            @(posedge clk);
        end
    endtask

    // Drains the block, then writes entry_count.
    task automatic write_count(input logic [CNT_W-1:0] v);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (playback_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_count = 32'(v);
    endtask

    task automatic send_query(input logic [TIME_W-1:0] now);
        predict_playback(now, 1'b0);
        send_word(FUNC_QUERY, IDX_W'($urandom()), CH_W'($urandom()), now, $urandom());
    endtask

    function automatic void add_row(input bit is_cfg, input logic func,
                                    input int idx, input int ch,
                                    input logic [31:0] t, input logic [31:0] v,
                                    input bit exh);
        dir_row_t r;
        r.is_cfg    = is_cfg;
        r.func      = func;
        r.idx       = idx[IDX_W-1:0];
        r.ch        = ch[CH_W-1:0];
        r.t         = t;
        r.v         = v;
        r.exhausted = exh;
        dir_tab.push_back(r);
    endfunction

    // Receiver stall pattern: free-running, switching at random between always ready, random and mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b1;
            rx_cycle <= 0;
            rx_mode  <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 63)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Output check and watchdog, sampled mid-cycle where everything is settled.
    always @(negedge clk)
    begin
        playback_word_t exp_w;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIM)
            begin
                $display("[timed_sample_playback_interpolator] ERROR");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (playback_q.size() == 0)
                begin
                    $error("unexpected output word: tdata %h tuser %b", m_tdata, m_tuser);
                    fails++;
                end
                else
                begin
                    exp_w = playback_q.pop_front();
                    if (m_tuser[0] !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status, m_tuser[0]);
                        fails++;
                    end
                    if (m_tdata[3:0] !== exp_w.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", exp_w.ch, m_tdata[3:0]);
                        fails++;
                    end
                    if (m_tdata[35:4] !== exp_w.value)
                    begin
                        $error("out_value: expected %h, got %h", exp_w.value, m_tdata[35:4]);
                        fails++;
                    end
                    if (m_tdata[67:36] !== exp_w.tstamp)
                    begin
                        $error("out_time: expected %h, got %h", exp_w.tstamp, m_tdata[67:36]);
                        fails++;
                    end
                    if (m_tlast !== exp_w.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_w.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned top;       // records 0..top-1 are fully loaded
        int unsigned nrec;
        int unsigned nq;
        logic [31:0] last_t;
        logic [31:0] now;
        logic [31:0] base_t;
        int unsigned cnt_v;
        int unsigned ref_i;

        fails        = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        shadow_index = 0;
        shadow_count = 0;
        foreach (shadow_mask[i])
            shadow_mask[i] = '0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, record 0 with extreme values, ignored loads,
        // record 0 as stored, and running past the end.
        add_row(0, FUNC_QUERY, 0, 0, 32'd0, 32'd0, 1);
        for (int c = 0; c < NCH; c++)
        begin
            case (c)
                0: add_row(0, FUNC_LOAD, 0, c, 32'd100, 32'h8000_0000, 0);
                1: add_row(0, FUNC_LOAD, 0, c, 32'd100, 32'h7FFF_FFFF, 0);
                2: add_row(0, FUNC_LOAD, 0, c, 32'd100, 32'h0000_0000, 0);
                3: add_row(0, FUNC_LOAD, 0, c, 32'd100, 32'hFFFF_FFFF, 0);
                4: add_row(0, FUNC_LOAD, 0, c, 32'd100, 32'h0001_0000, 0);
                default: add_row(0, FUNC_LOAD, 0, c, 32'd100, $urandom(), 0);
            endcase
        end
        add_row(0, FUNC_LOAD, 0, 15, 32'hFFFF_FFFF, 32'h1234_5678, 0);   // channel out of range
        add_row(0, FUNC_LOAD, 1023, 14, 32'd7, 32'h7FFF_FFFF, 0);        // channel out of range
        add_row(1, FUNC_LOAD, 0, 0, 32'd0, 32'd1, 0);                     // entry_count = 1
        add_row(0, FUNC_QUERY, 0, 0, 32'd50, 32'd0, 0);                   // index zero
        add_row(0, FUNC_QUERY, 0, 0, 32'd100, 32'd0, 0);                  // equal time, no walk
        add_row(0, FUNC_QUERY, 1023, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1); // exhausted

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_count(dir_tab[i].v[CNT_W-1:0]);
            else
            begin
                if (dir_tab[i].func == FUNC_QUERY)
                    predict_playback(dir_tab[i].t, dir_tab[i].exhausted);
                send_word(dir_tab[i].func, dir_tab[i].idx, dir_tab[i].ch,
                          dir_tab[i].t, dir_tab[i].v);
            end
        end

        // Random phases: load a few new records, set entry_count, query.
        top    = 1;
        last_t = 32'd100;
        for (int ph = 0; ph < 10; ph++)
        begin
            nrec = $urandom_range(1, 2);
            for (int r = 0; r < nrec; r++)
            begin
                if ($urandom_range(0, 5) == 0)
                    last_t = last_t - $urandom_range(1, 300);     // unsorted timestamps
                else if ($urandom_range(0, 9) == 0)
                    last_t = last_t + $urandom_range(1, 32'h0100_0000);
                else
                    last_t = last_t + $urandom_range(1, 5000);
                if (ph == 8 && r == nrec - 1)
                    last_t = 32'hFFFF_FFFF;
                for (int c = 0; c < NCH; c++)
                begin
                    send_word(FUNC_LOAD, top[IDX_W-1:0], c[CH_W-1:0], last_t, $urandom());
                    // occasional noise: ignored channel or an overwrite
                    if ($urandom_range(0, 9) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_word(FUNC_LOAD, IDX_W'($urandom()),
                                      CH_W'($urandom_range(14, 15)),
                                      $urandom(), $urandom());
                        else
                            send_word(FUNC_LOAD, IDX_W'($urandom_range(0, top - 1)),
                                      CH_W'($urandom_range(0, NCH - 1)),
                                      $urandom(), $urandom());
                    end
                end
                top++;
            end

            case (ph)
                3:       cnt_v = 0;
                6:       cnt_v = NREC;
                9:       cnt_v = 2047;
                default: cnt_v = ($urandom_range(0, 3) == 0) ? top - 1 : top;
            endcase
            write_count(cnt_v[CNT_W-1:0]);

            nq = $urandom_range(4, 7);
            for (int q = 0; q < nq; q++)
            begin
                ref_i  = (shadow_index < top) ? shadow_index : top - 1;
                base_t = shadow_time[ref_i];
                case ($urandom_range(0, 7))
                    0:       now = $urandom();
                    1:       now = 32'd0;
                    2:       now = 32'hFFFF_FFFF;
                    3:       now = base_t + $urandom_range(0, 3000);
                    default: now = base_t - $urandom_range(0, 3000);
                endcase
                if (!query_is_safe(now))
                    now = (shadow_index < top) ? shadow_time[shadow_index] : 32'd0;
                if (query_is_safe(now))
                    send_query(now);
            end
        end

        s_tvalid <= 1'b0;
        while (playback_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("[timed_sample_playback_interpolator] OK");
        else
            $display("[timed_sample_playback_interpolator] ERROR");
        $finish;
    end

endmodule
